FILE: rtl/core/poi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package poi_pkg;

    localparam int DataW      = 32;
    localparam int CordicN    = 30;
    localparam int CordicW    = 38;
    localparam int AccW       = 40;
    localparam logic signed [34:0] PiQ29     = 35'sd1686629713;
    localparam logic signed [34:0] TwoPiQ29  = 35'sd3373259426;
    localparam logic signed [CordicW-1:0] PiQ30     = 38'sd3373259426;
    localparam logic signed [CordicW-1:0] HalfPiQ30 = 38'sd1686629713;
    localparam logic signed [CordicW-1:0] GainInv   = 38'sd652032874;
    localparam logic signed [CordicW-1:0] OneQ30    = 38'sd1073741824;

    localparam logic OP_RESTART   = 1'b0;
    localparam logic OP_INTEGRATE = 1'b1;

    localparam logic [1:0] REG_START_X   = 2'd0;
    localparam logic [1:0] REG_START_Y   = 2'd1;
    localparam logic [1:0] REG_START_YAW = 2'd2;

    typedef struct packed {
        logic load;
        logic restart;
        logic mac_step;
        logic cordic_init;
        logic cordic_step;
        logic rot_step;
        logic finish;
    } poi_cmd_t;

    function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h00100000; 5'd11: v = 32'h00080000;
            5'd12: v = 32'h00040000; 5'd13: v = 32'h00020000;
            5'd14: v = 32'h00010000; 5'd15: v = 32'h00008000;
            5'd16: v = 32'h00004000; 5'd17: v = 32'h00002000;
            5'd18: v = 32'h00001000; 5'd19: v = 32'h00000800;
            5'd20: v = 32'h00000400; 5'd21: v = 32'h00000200;
            5'd22: v = 32'h00000100; 5'd23: v = 32'h00000080;
            5'd24: v = 32'h00000040; 5'd25: v = 32'h00000020;
            5'd26: v = 32'h00000010; 5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return signed'({6'd0, v});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/planar_odometry_integrator.sv
// Requests are processed one at a time: restart is load, then hand-off; integrate is load,
// 12 MAC steps, 1 set-up, 30 CORDIC steps, 4 rotation steps, 1 hand-off. The hand-off waits
// while the output register still holds a result that has not been taken.
// Result held in an output register; a new request is taken once the previous result is in it.
// Reset (rst_n, async low) clears references, held pose and start registers.
`timescale 1ns / 1ps
`default_nettype none
module planar_odometry_integrator
    import poi_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [295:0] s_tdata,  // rot_xx,rot_yx,rot_zx,rot_xy,rot_yy,rot_zy,pos_x,pos_y,pos_z
    input  wire logic         s_tuser,  // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,  // pose_x, pose_y, pose_yaw
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic signed [31:0] sx_reg, sy_reg, syaw_reg;
    logic signed [31:0] hx, hy, hyaw;
    poi_cmd_t   cmd;
    logic [4:0] step;
    logic       busy;
    logic       mv_reg;
    logic       start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0; sy_reg <= '0; syaw_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_X:   sx_reg   <= cfg_data;
                REG_START_Y:   sy_reg   <= cfg_data;
                REG_START_YAW: syaw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && !busy;

    poi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .op(s_tuser),
        .out_free(!mv_reg || m_tready), .cmd(cmd), .step(step), .busy(busy)
    );

    poi_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .step(step),
        .in_vec(s_tdata[287:0]), .start_x(sx_reg), .start_y(sy_reg),
        .start_yaw(syaw_reg), .held_x(hx), .held_y(hy), .held_yaw(hyaw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (cmd.finish)
            mv_reg <= 1'b1;
        else if (m_tready)
            mv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            m_tdata <= {hyaw, hy, hx};
    end

    assign m_tvalid = mv_reg;

endmodule
`default_nettype wire

FILE: rtl/core/poi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module poi_ctrl
    import poi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     op,
    input  wire logic     out_free,
    output poi_cmd_t      cmd,
    output logic [4:0]    step,
    output logic          busy
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MAC    = 6'b000010,
        S_CINIT  = 6'b000100,
        S_CORDIC = 6'b001000,
        S_ROT    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (op == OP_RESTART)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd11)
                    state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CordicN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign step = cnt_reg;
    assign busy = (state_reg != S_IDLE);

    ap_cnt_mac: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> cnt_reg <= 5'd11) else $error("mac count");
    ap_cnt_rot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT |-> cnt_reg <= 5'd3) else $error("rot count");
    ap_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_MAC || state_reg == S_DONE) else $error("start");

endmodule
`default_nettype wire

FILE: rtl/core/poi_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module poi_dpath
    import poi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire poi_cmd_t           cmd,
    input  wire logic [4:0]         step,
    input  wire logic [9*DataW-1:0] in_vec,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_yaw,
    output logic signed [31:0]      held_x,
    output logic signed [31:0]      held_y,
    output logic signed [31:0]      held_yaw
);

    logic signed [31:0] cur_reg [9];
    logic signed [31:0] ref_reg [9];
    logic signed [31:0] hx_reg, hy_reg, hyaw_reg;
    logic signed [AccW-1:0] dx_reg, dy_reg, a_reg, b_reg;
    logic signed [CordicW-1:0] ax_reg, ay_reg, az_reg, sx_reg, sy_reg, sz_reg;
    logic flip_reg;
    logic signed [AccW-1:0] dxs_reg, dys_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] rx_reg, ry_reg;

    // MAC schedule: steps 0..11 = (term, axis); product then accumulate next step
    logic [1:0]  term, term_d;
    logic [1:0]  axis;
    logic signed [32:0] op_b;
    logic signed [31:0] op_a;
    logic signed [65:0] prod;
    logic signed [AccW-1:0] prod_rnd;
    logic [4:0]  prev;

    always_comb
    begin
        term = step[1:0];
        axis = 2'(step[4:2]);
        unique case (term)
            2'd0: op_a = ref_reg[4'(axis)];
            2'd1: op_a = ref_reg[4'd3 + 4'(axis)];
            2'd2: op_a = ref_reg[4'(axis)];
            default: op_a = ref_reg[4'd3 + 4'(axis)];
        endcase
        if (term[1])
            op_b = 33'(cur_reg[4'(axis)]);
        else
            op_b = 33'(cur_reg[4'd6 + 4'(axis)]) - 33'(ref_reg[4'd6 + 4'(axis)]);
        prod = 66'(op_a) * 66'(op_b);
        prev = step - 5'd1;
        term_d = prev[1:0];
        prod_rnd = AccW'((prod_reg + 66'sd536870912) >>> 30);
    end

    function automatic logic signed [AccW-1:0] sat40(input logic signed [AccW-1:0] v);
        if (v > 40'sd2147483647) return 40'sd2147483647;
        if (v < -40'sd2147483648) return -40'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] wrap(input logic signed [34:0] v);
        logic signed [34:0] r;
        r = v;
        if (v > PiQ29) r = v - TwoPiQ29;
        else if (v < -PiQ29) r = v + TwoPiQ29;
        return 32'(r);
    endfunction

    logic signed [CordicW-1:0] axs, ays, sxs, sys, at;
    logic signed [CordicW:0]   zsum;
    logic signed [CordicW-1:0] zr;
    logic signed [CordicW-1:0] cx, cy;
    always_comb
    begin
        axs = ax_reg >>> step;
        ays = ay_reg >>> step;
        sxs = sx_reg >>> step;
        sys = sy_reg >>> step;
        at  = atan_q30(step);
        zsum = (CordicW+1)'(az_reg) + 39'sd1;
        zr   = CordicW'(zsum >>> 1);
        if (zr > 38'(PiQ29)) zr = 38'(PiQ29);
        else if (zr < -38'(PiQ29)) zr = -38'(PiQ29);
        cx = flip_reg ? -sx_reg : sx_reg;
        cy = flip_reg ? -sy_reg : sy_reg;
        if (cx > OneQ30) cx = OneQ30; else if (cx < -OneQ30) cx = -OneQ30;
        if (cy > OneQ30) cy = OneQ30; else if (cy < -OneQ30) cy = -OneQ30;
    end

    logic signed [37:0] z0;
    always_comb z0 = 38'(hyaw_reg) <<< 1;

    // rotation: cos/sin of held heading; prod pairs c*dx, s*dy, s*dx, c*dy
    logic signed [63:0] rprod;
    logic signed [31:0] rm;
    logic signed [31:0] rv;
    logic signed [63:0] nx, ny;
    always_comb
    begin
        rm = (step[1:0] == 2'd0 || step[1:0] == 2'd3) ? 32'(cx) : 32'(cy);
        rv = (step[1:0] == 2'd1 || step[1:0] == 2'd3) ? 32'(dys_reg) : 32'(dxs_reg);
        rprod = 64'(rm) * 64'(rv);
        nx = ((rx_reg + 64'sd536870912) >>> 30) + 64'(hx_reg);
        ny = ((ry_reg + rprod + 64'sd536870912) >>> 30) + 64'(hy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++) ref_reg[k] <= '0;
            hx_reg <= '0; hy_reg <= '0; hyaw_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                hx_reg   <= start_x;
                hy_reg   <= start_y;
                hyaw_reg <= wrap(35'(start_yaw));
            end
            if (cmd.rot_step && step == 5'd3)
            begin
                hx_reg   <= 32'(sat40(AccW'(nx)));
                hy_reg   <= 32'(sat40(AccW'(ny)));
                hyaw_reg <= wrap(35'(hyaw_reg) + 35'(zr));
            end
            if (cmd.finish)
                for (int k = 0; k < 9; k++) ref_reg[k] <= cur_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 9; k++) cur_reg[k] <= in_vec[k*32 +: 32];
            dx_reg <= '0; dy_reg <= '0; a_reg <= '0; b_reg <= '0;
        end
        if (cmd.mac_step)
            prod_reg <= prod;
        if ((cmd.mac_step && step != 5'd0) || cmd.cordic_init)
        begin
            unique case (term_d)
                2'd0: dx_reg <= dx_reg + prod_rnd;
                2'd1: dy_reg <= dy_reg + prod_rnd;
                2'd2: a_reg  <= a_reg + prod_rnd;
                default: b_reg <= b_reg + prod_rnd;
            endcase
        end
        if (cmd.cordic_init)
        begin
            // atan2 vectoring set-up (b includes last product, term 3)
            if (a_reg < 0)
            begin
                ax_reg <= -CordicW'(a_reg);
                ay_reg <= -CordicW'(b_reg + prod_rnd);
                az_reg <= (b_reg + prod_rnd >= 0) ? PiQ30 : -PiQ30;
            end
            else
            begin
                ax_reg <= CordicW'(a_reg);
                ay_reg <= CordicW'(b_reg + prod_rnd);
                az_reg <= '0;
            end
            sx_reg <= GainInv;
            sy_reg <= '0;
            if (z0 > HalfPiQ30)
            begin
                sz_reg <= z0 - PiQ30; flip_reg <= 1'b1;
            end
            else if (z0 < -HalfPiQ30)
            begin
                sz_reg <= z0 + PiQ30; flip_reg <= 1'b1;
            end
            else
            begin
                sz_reg <= z0; flip_reg <= 1'b0;
            end
            dxs_reg <= sat40(dx_reg);
            dys_reg <= sat40(dy_reg);
        end
        if (cmd.cordic_step)
        begin
            if (ay_reg > 0)
            begin
                ax_reg <= ax_reg + ays; ay_reg <= ay_reg - axs;
            end
            else
            begin
                ax_reg <= ax_reg - ays; ay_reg <= ay_reg + axs;
            end
            // zero vector gives a zero step
            if (step == 5'(CordicN - 1) && a_reg == 0 && b_reg == 0)
                az_reg <= '0;
            else if (ay_reg > 0)
                az_reg <= az_reg + at;
            else
                az_reg <= az_reg - at;
            if (sz_reg >= 0)
            begin
                sx_reg <= sx_reg - sys; sy_reg <= sy_reg + sxs; sz_reg <= sz_reg - at;
            end
            else
            begin
                sx_reg <= sx_reg + sys; sy_reg <= sy_reg - sxs; sz_reg <= sz_reg + at;
            end
        end
        if (cmd.rot_step && step != 5'd3)
        begin
            unique case (step[1:0])
                2'd0: rx_reg <= rprod;
                2'd1: rx_reg <= rx_reg - rprod;
                default: ry_reg <= rprod;
            endcase
        end
        if (cmd.rot_step && step == 5'd3)
            ry_reg <= ry_reg + rprod;
    end

    assign held_x   = hx_reg;
    assign held_y   = hy_reg;
    assign held_yaw = hyaw_reg;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import poi_pkg::*;

    typedef struct {
        logic              op;
        logic signed [31:0] col0 [3];
        logic signed [31:0] col1 [3];
        logic signed [31:0] pos [3];
    } odo_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] yaw;
    } pose_t;

    localparam longint PI29 = 1686629713;
    localparam longint PI30 = 64'sd3373259426;
    localparam longint HPI30 = 1686629713;
    localparam longint GINV = 652032874;
    localparam longint ONE30 = 1073741824;
    localparam int TIMEOUT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [295:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;

    longint start_x, start_y, start_yaw;
    longint rcol_x [3];
    longint rcol_y [3];
    longint rtrans [3];
    longint hx, hy, hyaw;
    pose_t pose_q [$];

    planar_odometry_integrator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT)
        begin
            $display("planar_odometry_integrator regression: fail");
            $finish;
        end
    end

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rshift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return clampl(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint wrap_heading(longint v);
        if (v > PI29)
            return v - 2 * PI29;
        if (v < -PI29)
            return v + 2 * PI29;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        return longint'(atan_q30(5'(i)));
    endfunction

    function automatic longint heading_step(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI30 : -PI30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_entry(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_entry(i);
            end
        end
        return clampl(rshift(z, 1), -PI29, PI29);
    endfunction

    task automatic heading_sincos(input longint yaw, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = 2 * yaw;
        x = GINV;
        y = 0;
        flip = 0;
        if (z > HPI30)
        begin
            z -= PI30; flip = 1;
        end
        else if (z < -HPI30)
        begin
            z += PI30; flip = 1;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_entry(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_entry(i);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clampl(x, -ONE30, ONE30);
        s = clampl(y, -ONE30, ONE30);
    endtask

    task automatic integrate_pose(input odo_t it);
        longint dx, dy, a, b, c, s, step, d;
        pose_t p;
        dx = 0; dy = 0; a = 0; b = 0;
        if (it.op == OP_RESTART)
        begin
            hx = start_x;
            hy = start_y;
            hyaw = wrap_heading(start_yaw);
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                d = longint'(it.pos[k]) - rtrans[k];
                dx += rshift(rcol_x[k] * d, 30);
                dy += rshift(rcol_y[k] * d, 30);
                a += rshift(rcol_x[k] * longint'(it.col0[k]), 30);
                b += rshift(rcol_y[k] * longint'(it.col0[k]), 30);
            end
            dx = sat32(dx);
            dy = sat32(dy);
            step = heading_step(b, a);
            heading_sincos(hyaw, c, s);
            hx = sat32(hx + rshift(c * dx - s * dy, 30));
            hy = sat32(hy + rshift(s * dx + c * dy, 30));
            hyaw = wrap_heading(hyaw + step);
        end
        for (int k = 0; k < 3; k++)
        begin
            rcol_x[k] = it.col0[k];
            rcol_y[k] = it.col1[k];
            rtrans[k] = it.pos[k];
        end
        p.x = hx[31:0];
        p.y = hy[31:0];
        p.yaw = hyaw[31:0];
        pose_q.push_back(p);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        pose_t w;
        if (m_tvalid && m_tready)
        begin
            if (pose_q.size() == 0)
                report("unexpected pose", m_tdata[31:0], 32'h0);
            else
            begin
                w = pose_q.pop_front();
                if (m_tdata[31:0] !== w.x)
                    report("pose_x", m_tdata[31:0], w.x);
                if (m_tdata[63:32] !== w.y)
                    report("pose_y", m_tdata[63:32], w.y);
                if (m_tdata[95:64] !== w.yaw)
                    report("pose_yaw", m_tdata[95:64], w.yaw);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input odo_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {8'h0, it.pos[2], it.pos[1], it.pos[0],
                    it.col1[2], it.col1[1], it.col1[0],
                    it.col0[2], it.col0[1], it.col0[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        integrate_pose(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_X:   start_x = longint'(signed'(v));
            REG_START_Y:   start_y = longint'(signed'(v));
            REG_START_YAW: start_yaw = longint'(signed'(v));
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] small_q30();
        return 32'($urandom_range(2147483647)) - 32'd1073741824;
    endfunction

    function automatic odo_t rand_odo(input logic op, input bit wild);
        odo_t it;
        real th;
        it.op = op;
        th = ($urandom_range(65535) / 65536.0 - 0.5) * 6.2831853;
        if (wild)
        begin
            for (int k = 0; k < 3; k++)
            begin
                it.col0[k] = small_q30();
                it.col1[k] = small_q30();
                it.pos[k] = $urandom;
            end
        end
        else
        begin
            it.col0[0] = $rtoi($cos(th) * 1073741823.0);
            it.col0[1] = $rtoi($sin(th) * 1073741823.0);
            it.col0[2] = $urandom_range(2000) - 1000;
            it.col1[0] = -it.col0[1];
            it.col1[1] = it.col0[0];
            it.col1[2] = $urandom_range(2000) - 1000;
            for (int k = 0; k < 3; k++)
                it.pos[k] = $urandom_range(1 << 24) - (1 << 23);
        end
        return it;
    endfunction

    function automatic odo_t fill_odo(input logic op, input logic [31:0] c, input logic [31:0] p);
        odo_t it;
        it.op = op;
        for (int k = 0; k < 3; k++)
        begin
            it.col0[k] = c;
            it.col1[k] = c;
            it.pos[k] = p;
        end
        return it;
    endfunction

    task automatic test_directed();
        odo_t it;
        send_request(rand_odo(OP_INTEGRATE, 0));
        send_request(fill_odo(OP_INTEGRATE, 32'h0, 32'h0));
        send_request(fill_odo(OP_RESTART, 32'h40000000, 32'h7FFFFFFF));
        send_request(fill_odo(OP_INTEGRATE, 32'hC0000000, 32'h80000000));
        send_request(fill_odo(OP_INTEGRATE, 32'h40000000, 32'h7FFFFFFF));
        send_request(fill_odo(OP_INTEGRATE, 32'h0, 32'h0));
        send_request(fill_odo(OP_INTEGRATE, 32'h0, 32'h0));
        send_request(fill_odo(OP_INTEGRATE, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_request(fill_odo(OP_INTEGRATE, 32'h80000000, 32'h80000000));
        send_request(fill_odo(OP_INTEGRATE, 32'h7FFFFFFF, 32'h7FFFFFFF));
        it = fill_odo(OP_RESTART, 32'h0, 32'h0);
        it.col0[0] = 32'h40000000; it.col1[1] = 32'h40000000;
        send_request(it);
        it.op = OP_INTEGRATE;
        it.col0[0] = 32'hC0000000; it.col0[1] = 32'h0;
        send_request(it);
        it.col0[0] = 32'h40000000; it.col0[1] = 32'h00000001;
        send_request(it);
        it.col0[0] = 32'hC0000000; it.col0[1] = 32'hFFFFFFFF;
        send_request(it);
        for (int i = 0; i < 8; i++)
            send_request(rand_odo(OP_INTEGRATE, 0));
        drain();
    endtask

    task automatic test_start_pose(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] yaw);
        write_reg(REG_START_X, x);
        write_reg(REG_START_Y, y);
        write_reg(REG_START_YAW, yaw);
        send_request(rand_odo(OP_RESTART, 0));
        for (int i = 0; i < 6; i++)
            send_request(rand_odo(OP_INTEGRATE, 0));
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_request(rand_odo(OP_RESTART, $urandom_range(3) == 0));
            else
                send_request(rand_odo(OP_INTEGRATE, $urandom_range(9) == 0));
            if (i == n / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        for (int k = 0; k < 3; k++)
        begin
            rcol_x[k] = 0; rcol_y[k] = 0; rtrans[k] = 0;
        end
        start_x = 0; start_y = 0; start_yaw = 0;
        hx = 0; hy = 0; hyaw = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_start_pose(32'h7FFFFFFF, 32'h80000000, 32'(PI29));
        test_start_pose(32'h80000000, 32'h7FFFFFFF, 32'(-PI29));
        test_start_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        test_start_pose(32'h80000000, 32'h80000000, 32'h80000000);
        test_start_pose($urandom, $urandom, 32'($urandom_range(32'd3373259426)) - 32'(PI29));
        test_random(400, 0, 0);
        test_random(250, 87, 0);
        test_random(250, 0, 87);
        write_reg(REG_START_X, $urandom);
        write_reg(REG_START_Y, $urandom);
        write_reg(REG_START_YAW, 32'd12345);
        test_random(300, 14, 14);
        if (errors == 0)
            $display("planar_odometry_integrator regression: pass");
        else
            $display("planar_odometry_integrator regression: fail");
        $finish;
    end
endmodule
